/* design/selective_ack_retransmit_tracker_assert.svh */
// Assertion macros for the selective-ack retransmit tracker.
// Depends on nothing; included by modules that check their own logic.
`ifndef SELECTIVE_ACK_RETRANSMIT_TRACKER_ASSERT_SVH
`define SELECTIVE_ACK_RETRANSMIT_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define SART_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sart: same-cycle check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define SART_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sart: next-cycle check failed");

`endif

/* design/sart_pkg.sv */
// Shared types and constants for the selective-ack retransmit tracker.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package sart_pkg;

   // Window slots; a power of two so the slot is the low bits of the sequence.
   localparam int WINDOW      = 32;
   localparam int SLOT_W      = $clog2(WINDOW);
   localparam int ACK_BITS    = 32;
   localparam int STEP_W      = $clog2(ACK_BITS + 1);
   localparam int CNT_W       = $clog2(ACK_BITS + 2);
   localparam int SEQ_W       = 16;
   localparam int AGE_W       = 16;
   localparam int RETRY_W     = 8;
   localparam int DELAY_W     = 16;
   localparam int LIMIT_W     = DELAY_W + RETRY_W + 1;
   localparam int CLEARED_W   = 6;
   localparam int CMDQ_DEPTH  = 2;
   localparam int RSPQ_DEPTH  = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [DELAY_W-1:0] DELAY_RESET   = 16'd100;
   localparam logic [RETRY_W-1:0] RETRIES_RESET = 8'd5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY       = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RETRIES = 1'd1;

   // Request modes
   localparam logic [1:0] MODE_REGISTER = 2'd0;
   localparam logic [1:0] MODE_ACK      = 2'd1;
   localparam logic [1:0] MODE_TICK     = 2'd2;

   // Result events
   localparam logic [2:0] EV_REGISTERED = 3'd0;
   localparam logic [2:0] EV_ACKED      = 3'd1;
   localparam logic [2:0] EV_RETRANSMIT = 3'd2;
   localparam logic [2:0] EV_LOST       = 3'd3;
   localparam logic [2:0] EV_TICK_DONE  = 3'd4;

   typedef struct packed {
      logic [1:0]          mode;
      logic [SEQ_W-1:0]    seq;
      logic [31:0]         ack_bits;
   } req_type;

   typedef struct packed {
      logic [2:0]           event_res;
      logic [SEQ_W-1:0]     out_seq;
      logic [RETRY_W-1:0]   retry_count;
      logic [CLEARED_W-1:0] cleared;
      logic                 last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_REGISTER,
      CMD_ACK,
      CMD_TICK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [SEQ_W-1:0]    seq;
      logic [31:0]         ack_bits;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACK,
      ST_ACK_DONE,
      ST_TICK,
      ST_TICK_DONE
   } back_state_type;

endpackage

/* design/sart_front.sv */
// Front end: accepts requests, classifies them and queues commands.
// Depends on sart_pkg.
`timescale 1ns / 1ps

module sart_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  sart_pkg::req_type req_data,
   output logic              cmd_valid,
   output sart_pkg::cmd_type cmd_data,
   input  logic              cmd_pop
);
   import sart_pkg::*;

   localparam int PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CNT_QW = $clog2(CMDQ_DEPTH + 1);

   cmd_type             queue_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]   count_ff, count_in;
   cmd_type             cmd_new;
   logic                keep;
   logic                enq;
   logic                deq;

   // Map mode to command kind; the unused mode is dropped here.
   always_comb begin
      cmd_new.seq      = req_data.seq;
      cmd_new.ack_bits = req_data.ack_bits;
      cmd_new.kind     = CMD_REGISTER;
      keep             = 1'b1;
      unique case (req_data.mode)
         MODE_REGISTER: cmd_new.kind = CMD_REGISTER;
         MODE_ACK:      cmd_new.kind = CMD_ACK;
         MODE_TICK:     cmd_new.kind = CMD_TICK;
         default:       keep = 1'b0;
      endcase
   end

   assign req_full  = (count_ff == CNT_QW'(CMDQ_DEPTH));
   assign enq       = req_push && !req_full && keep;
   assign deq       = cmd_pop && cmd_valid;
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (enq) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (enq && !deq) begin
         count_in = count_ff + 1'b1;
      end else if (deq && !enq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

/* design/sart_rsp_queue.sv */
// Result queue: holds finished results until the consumer pops them.
// Depends on sart_pkg.
`timescale 1ns / 1ps

module sart_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              res_valid,
   input  sart_pkg::rsp_type res_data,
   output logic              res_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output sart_pkg::rsp_type rsp_data
);
   import sart_pkg::*;

   localparam int PTR_W = $clog2(RSPQ_DEPTH);
   localparam int CNT_QW = $clog2(RSPQ_DEPTH + 1);

   rsp_type            queue_ff [RSPQ_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]  count_ff, count_in;
   logic               enq;
   logic               deq;

   assign res_full  = (count_ff == CNT_QW'(RSPQ_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign enq       = res_valid && !res_full;
   assign deq       = rsp_pop && !rsp_empty;
   assign rsp_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (enq) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(RSPQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(RSPQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (enq && !deq) begin
         count_in = count_ff + 1'b1;
      end else if (deq && !enq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         queue_ff[wr_ptr_ff] <= res_data;
      end
   end

endmodule

/* design/sart_back.sv */
// Back end: window store, acknowledgement sequencer and two-stage tick scan.
// Depends on sart_pkg and selective_ack_retransmit_tracker_assert.svh.
`timescale 1ns / 1ps

`include "selective_ack_retransmit_tracker_assert.svh"

module sart_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [sart_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sart_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                cmd_valid,
   input  sart_pkg::cmd_type                   cmd_data,
   output logic                                cmd_pop,
   output logic                                res_valid,
   output sart_pkg::rsp_type                   res_data,
   input  logic                                res_full
);
   import sart_pkg::*;

   back_state_type        state_ff, state_in;

   logic [DELAY_W-1:0]    delay_ff;
   logic [RETRY_W-1:0]    max_retries_ff;

   logic                  entry_valid_ff   [WINDOW];
   logic [SEQ_W-1:0]      entry_seq_ff     [WINDOW];
   logic [AGE_W-1:0]      entry_age_ff     [WINDOW];
   logic [RETRY_W-1:0]    entry_retries_ff [WINDOW];

   // Acknowledgement sequencer
   logic [SEQ_W-1:0]      aseq_ff, aseq_in;
   logic [ACK_BITS-1:0]   bits_ff, bits_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SEQ_W-1:0]      target;
   logic [SLOT_W-1:0]     tslot;
   logic                  ack_en;
   logic                  ack_hit;

   // Tick scan, stage one reads and multiplies, stage two decides
   logic [SLOT_W:0]       rd_idx_ff, rd_idx_in;
   logic [SLOT_W-1:0]     rslot;
   logic                  s1_live;
   logic [AGE_W-1:0]      s1_age;
   logic [LIMIT_W-1:0]    s1_limit;
   logic                  s2_live_ff, s2_live_in;
   logic [SLOT_W-1:0]     s2_slot_ff;
   logic [AGE_W-1:0]      s2_age_ff;
   logic [RETRY_W-1:0]    s2_retries_ff;
   logic [SEQ_W-1:0]      s2_seq_ff;
   logic [LIMIT_W-1:0]    s2_limit_ff;
   logic                  expire;
   logic                  can_retry;
   logic                  stall;
   logic                  s2_load;
   logic                  tick_we;
   logic                  reg_we;
   logic [SLOT_W-1:0]     reg_slot;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff       <= DELAY_RESET;
         max_retries_ff <= RETRIES_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DELAY:       delay_ff       <= csr_wdata[DELAY_W-1:0];
            CSR_MAX_RETRIES: max_retries_ff <= csr_wdata[RETRY_W-1:0];
            default:         ;
         endcase
      end
   end

   assign cmd_pop  = cmd_valid && (state_ff == ST_IDLE) && !res_full;
   assign reg_we   = cmd_pop && (cmd_data.kind == CMD_REGISTER);
   assign reg_slot = cmd_data.seq[SLOT_W-1:0];

   // Step zero targets the acknowledged sequence, step k the one k below it
   assign target  = aseq_ff - SEQ_W'(step_ff);
   assign tslot   = target[SLOT_W-1:0];
   assign ack_en  = (step_ff == '0) || bits_ff[0];
   assign ack_hit = (state_ff == ST_ACK) && ack_en && entry_valid_ff[tslot]
                    && (entry_seq_ff[tslot] == target);

   assign rslot   = rd_idx_ff[SLOT_W-1:0];
   assign s1_live = !rd_idx_ff[SLOT_W] && entry_valid_ff[rslot];
   assign s1_age  = (entry_age_ff[rslot] == '1) ? entry_age_ff[rslot]
                                                : entry_age_ff[rslot] + 1'b1;
   assign s1_limit = LIMIT_W'(delay_ff) * (LIMIT_W'(entry_retries_ff[rslot]) + 1'b1);

   assign expire    = s2_live_ff && (LIMIT_W'(s2_age_ff) > s2_limit_ff);
   assign can_retry = s2_retries_ff < max_retries_ff;
   assign stall     = expire && res_full;
   assign s2_load   = (state_ff == ST_TICK) && !stall;
   assign tick_we   = s2_load && s2_live_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_idx_ff  <= '0;
         s2_live_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_idx_ff  <= rd_idx_in;
         s2_live_ff <= s2_live_in;
      end
   end

   always_ff @(posedge clock) begin
      aseq_ff  <= aseq_in;
      bits_ff  <= bits_in;
      step_ff  <= step_in;
      count_ff <= count_in;
      if (s2_load) begin
         s2_slot_ff    <= rslot;
         s2_age_ff     <= s1_age;
         s2_retries_ff <= entry_retries_ff[rslot];
         s2_seq_ff     <= entry_seq_ff[rslot];
         s2_limit_ff   <= s1_limit;
      end
   end

   // Valid bits: set on register, clear on ack hit or loss
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            entry_valid_ff[i] <= 1'b0;
         end
      end else begin
         if (reg_we) begin
            entry_valid_ff[reg_slot] <= 1'b1;
         end
         if (ack_hit) begin
            entry_valid_ff[tslot] <= 1'b0;
         end
         if (tick_we && expire && !can_retry) begin
            entry_valid_ff[s2_slot_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reg_we) begin
         entry_seq_ff[reg_slot]     <= cmd_data.seq;
         entry_age_ff[reg_slot]     <= '0;
         entry_retries_ff[reg_slot] <= '0;
      end else if (tick_we) begin
         if (!expire) begin
            entry_age_ff[s2_slot_ff] <= s2_age_ff;
         end else if (can_retry) begin
            entry_age_ff[s2_slot_ff]     <= '0;
            entry_retries_ff[s2_slot_ff] <= s2_retries_ff + 1'b1;
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      aseq_in    = aseq_ff;
      bits_in    = bits_ff;
      step_in    = step_ff;
      count_in   = count_ff;
      rd_idx_in  = rd_idx_ff;
      s2_live_in = s2_live_ff;
      res_valid  = 1'b0;
      res_data   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            rd_idx_in  = '0;
            s2_live_in = 1'b0;
            if (cmd_pop) begin
               aseq_in  = cmd_data.seq;
               bits_in  = cmd_data.ack_bits[ACK_BITS-1:0];
               step_in  = '0;
               count_in = '0;
               unique case (cmd_data.kind)
                  CMD_REGISTER: begin
                     res_valid          = 1'b1;
                     res_data.event_res = EV_REGISTERED;
                     res_data.out_seq   = cmd_data.seq;
                     res_data.last      = 1'b1;
                  end
                  CMD_ACK:  state_in = ST_ACK;
                  CMD_TICK: state_in = ST_TICK;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_ACK: begin
            count_in = count_ff + CNT_W'(ack_hit);
            step_in  = step_ff + 1'b1;
            if (step_ff != '0) begin
               bits_in = bits_ff >> 1;
            end
            if (step_ff == STEP_W'(ACK_BITS)) begin
               state_in = ST_ACK_DONE;
            end
         end
         ST_ACK_DONE: begin
            if (!res_full) begin
               res_valid          = 1'b1;
               res_data.event_res = EV_ACKED;
               res_data.out_seq   = aseq_ff;
               res_data.cleared   = CLEARED_W'(count_ff);
               res_data.last      = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         ST_TICK: begin
            if (expire && !res_full) begin
               res_valid          = 1'b1;
               res_data.event_res = can_retry ? EV_RETRANSMIT : EV_LOST;
               res_data.out_seq   = s2_seq_ff;
               res_data.retry_count = can_retry ? s2_retries_ff + 1'b1 : s2_retries_ff;
            end
            if (!stall) begin
               s2_live_in = s1_live;
               if (rd_idx_ff[SLOT_W]) begin
                  state_in = ST_TICK_DONE;
               end else begin
                  rd_idx_in = rd_idx_ff + 1'b1;
               end
            end
         end
         ST_TICK_DONE: begin
            if (!res_full) begin
               res_valid          = 1'b1;
               res_data.event_res = EV_TICK_DONE;
               res_data.last      = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `SART_ASSERT_NOW(a_no_push_when_full, res_valid, !res_full)
   `SART_ASSERT_NOW(a_pop_only_idle, cmd_pop, state_ff == ST_IDLE)
   `SART_ASSERT_NEXT(a_scan_ends, (state_ff == ST_TICK) && rd_idx_ff[SLOT_W] && !stall,
                     state_ff == ST_TICK_DONE)
   `SART_ASSERT_NEXT(a_stall_holds_scan, (state_ff == ST_TICK) && stall,
                     $stable(rd_idx_ff) && (state_ff == ST_TICK))

endmodule

/* design/selective_ack_retransmit_tracker.sv */
// Top level of the selective-ack retransmit tracker for one peer.
// Depends on sart_pkg, sart_front, sart_back and sart_rsp_queue.
//
//   Channel | Ports                               | Moves
//   --------+-------------------------------------+-------------------------------
//   req     | req_push, req_full, req_data        | one request: register/ack/tick
//   rsp     | rsp_empty, rsp_pop, rsp_data        | one event; a tick gives up to 33
//   csr     | csr_we, csr_index, csr_wdata        | register write, no read-back
//
// Sequence: a register request is answered as the back end accepts it; an
// acknowledgement is accepted, probes the window once per target sequence, then
// gives the summary; a tick is accepted, moves one slot per cycle (unless a full
// result queue stalls it) through the two-stage scan, drains it, then reports tick-done.
// Reset: synchronous, active high; clears all valid bits at once and loads the
// register defaults (delay 100, retries 5), so no clearing pass is needed.
// Stalls: the command queue absorbs requests while the back end works; a full
// result queue holds the scan at its decision stage until space frees up.
`timescale 1ns / 1ps

module selective_ack_retransmit_tracker (
   input  logic                             clock,
   input  logic                             reset,
   // Request side
   input  logic                             req_push,
   output logic                             req_full,
   input  sart_pkg::req_type                req_data,
   // Result side
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output sart_pkg::rsp_type                rsp_data,
   // Register writes
   input  logic                             csr_we,
   input  logic [sart_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sart_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sart_pkg::*;

   // Front to back: classified commands, mode 3 already dropped
   logic     cmd_valid;
   cmd_type  cmd_data;
   logic     cmd_pop;

   // Back to result queue: one result per cycle at most
   logic     res_valid;
   rsp_type  res_data;
   logic     res_full;

   // Accept and classify requests; hold up to two commands
   sart_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   // Carry out commands against the window; owns the configuration registers
   sart_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_full  (res_full)
   );

   // Hold finished results until the consumer pops them
   sart_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_full  (res_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
